// ===== rtl/frb_pkg.sv =====
// frame builder package: shared types, constants and the failsafe code function
// used by the scheduler, lane, serialiser and top level; depends on nothing
package frb_pkg;

	localparam int STICK_W   = 15;
	localparam int CODE_W    = 12;
	localparam int CNT_W     = 10;
	localparam int HOP_W     = 5;
	localparam int CMD_W     = 4;
	localparam int LANES     = 4;
	localparam int CHANNELS  = 8;
	localparam int FRAME_LEN = 13;
	localparam int POS_W     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 64;

	localparam logic [POS_W-1:0] POS_LAST = 4'(FRAME_LEN - 1);

	// stick scaling
	localparam int STICK_MAX  = 16384;
	localparam int STICK_GAIN = 410;
	localparam int PROD_W     = 23;
	localparam logic signed [15:0] CODE_MID = 16'sd1520;
	localparam logic signed [15:0] CODE_MAX = 16'sd2135;
	localparam logic signed [15:0] CODE_MIN = 16'sd905;

	// failsafe coding
	localparam logic [12:0] FS_MID    = 13'h0C00;
	localparam logic [12:0] FS_CAP    = 13'h0DFF;
	localparam logic [17:0] FS_RECIP  = 18'd134218;
	localparam logic [CODE_W-1:0] HOLD_CODE     = 12'h400;
	localparam logic [CODE_W-1:0] THROTTLE_FLAG = 12'h800;

	// failsafe counter
	localparam logic [CNT_W-1:0] WRAP_MASK = 10'h3FC;

	// command bits
	localparam int CMD_SLOT  = 0;
	localparam int CMD_NORM  = 1;
	localparam int CMD_FS    = 2;
	localparam int CMD_UPPER = 3;

	localparam logic [7:0] FRAME_HEAD = 8'h81;
	localparam logic [6:0] HOP_LIMIT  = 7'd29;
	localparam logic [6:0] HOP_SKIP   = 7'd30;
	localparam logic [6:0] HOP_MOD    = 7'd31;
	localparam logic [7:0] SYNTH_BASE = 8'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TX_ID     = 3'd0,
		REG_HOP_CODE  = 3'd1,
		REG_FS_MASK   = 3'd2,
		REG_FS_VALUES = 3'd3,
		REG_ACTIVE    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_STICK = 2'd0,
		MODE_FS    = 2'd1,
		MODE_HOLD  = 2'd2
	} lane_mode_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [HOP_W-1:0] hop;
		logic [7:0]       synth;
	} pkt_info_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} pipe_en_t;

	typedef lane_mode_t [LANES-1:0] mode_vec_t;
	typedef logic [LANES-1:0][CODE_W-1:0] code_vec_t;

	function automatic logic [CODE_W-1:0] fs_code(input logic [7:0] b);
		logic [7:0]  m;
		logic [25:0] prod;
		logic [9:0]  mag;
		logic [12:0] v;
		m    = b[7] ? 8'(~b + 8'd1) : b;
		prod = 26'(m) * 26'(FS_RECIP);
		mag  = prod[24:15];
		v    = b[7] ? FS_MID + 13'(mag) : FS_MID - 13'(mag);
		if (v > FS_CAP) begin
			v = FS_CAP;
		end
		return v[CODE_W-1:0];
	endfunction

endpackage

// ===== rtl/fhss_rc_frame_builder.sv =====
// top level of the hopping rc frame builder: configuration registers,
// pipeline control, scheduler, four channel lanes and the serialiser; uses frb_pkg
// an item passes registered stages s1, s2, s3 and loads into the free serialiser, whose
// first byte is then valid; the serialiser emits one byte a cycle while out_stall is low
// a following item is taken and scaled while the current frame drains
// reset: asynchronous, clears pipeline, slot, counter and hop channel, config to defaults
module fhss_rc_frame_builder #(
	parameter int FULL_SCALE = 10000
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [frb_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [frb_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [frb_pkg::STICK_W-1:0]   stick_1,
	input  logic signed [frb_pkg::STICK_W-1:0]   stick_2,
	input  logic signed [frb_pkg::STICK_W-1:0]   stick_3,
	input  logic signed [frb_pkg::STICK_W-1:0]   stick_4,
	input  logic signed [frb_pkg::STICK_W-1:0]   stick_5,
	input  logic signed [frb_pkg::STICK_W-1:0]   stick_6,
	input  logic signed [frb_pkg::STICK_W-1:0]   stick_7,
	input  logic signed [frb_pkg::STICK_W-1:0]   stick_8,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [7:0]                           frame_byte,
	output logic [frb_pkg::POS_W-1:0]            byte_position,
	output logic                                 final_byte,
	output logic [7:0]                           synth_channel
);

	logic [15:0]                  tx_id_q;
	logic [frb_pkg::HOP_W-1:0]    hop_code_q;
	logic [7:0]                   fs_mask_q;
	logic [63:0]                  fs_values_q;
	logic [4:0]                   active_q;

	logic                         v_s1, v_s2, v_s3;
	frb_pkg::pkt_info_t           info_s1, info_s2, info_s3;
	frb_pkg::pkt_info_t           info_now;
	frb_pkg::mode_vec_t           modes;
	frb_pkg::pipe_en_t            pipe;
	frb_pkg::code_vec_t           codes;
	logic                         ready_s1, ready_s2, ready_s3;
	logic                         ser_ready;
	logic                         accept;
	logic                         load;

	logic signed [frb_pkg::STICK_W-1:0] sticks [frb_pkg::CHANNELS];

	assign sticks[0] = stick_1;
	assign sticks[1] = stick_2;
	assign sticks[2] = stick_3;
	assign sticks[3] = stick_4;
	assign sticks[4] = stick_5;
	assign sticks[5] = stick_6;
	assign sticks[6] = stick_7;
	assign sticks[7] = stick_8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_id_q     <= '0;
			hop_code_q  <= '0;
			fs_mask_q   <= '0;
			fs_values_q <= '0;
			active_q    <= 5'd8;
		end else if (cfg_we) begin
			unique case (frb_pkg::cfg_reg_t'(cfg_index))
				frb_pkg::REG_TX_ID:     tx_id_q     <= cfg_data[15:0];
				frb_pkg::REG_HOP_CODE:  hop_code_q  <= cfg_data[frb_pkg::HOP_W-1:0];
				frb_pkg::REG_FS_MASK:   fs_mask_q   <= cfg_data[7:0];
				frb_pkg::REG_FS_VALUES: fs_values_q <= cfg_data;
				frb_pkg::REG_ACTIVE:    active_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign load     = v_s3 && ser_ready;
	assign ready_s3 = !v_s3 || ser_ready;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign in_stall = !ready_s1;
	assign accept   = in_valid && ready_s1;

	assign pipe.en1 = accept;
	assign pipe.en2 = v_s1 && ready_s2;
	assign pipe.en3 = v_s2 && ready_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= in_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe.en1) begin
			info_s1 <= info_now;
		end
		if (pipe.en2) begin
			info_s2 <= info_s1;
		end
		if (pipe.en3) begin
			info_s3 <= info_s2;
		end
	end

	frb_sched u_sched (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.hop_code (hop_code_q),
		.fs_mask  (fs_mask_q),
		.active   (active_q),
		.info     (info_now),
		.modes    (modes)
	);

	for (genvar k = 0; k < frb_pkg::LANES; k++) begin : g_lane
		logic [2:0] idx;
		assign idx = {info_now.cmd[frb_pkg::CMD_UPPER], 2'(k)};

		frb_lane #(
			.FULL_SCALE (FULL_SCALE)
		) u_lane (
			.clk     (clk),
			.pipe    (pipe),
			.stick   (sticks[idx]),
			.mode    (modes[k]),
			.fs_byte (fs_values_q[8*idx +: 8]),
			.code    (codes[k])
		);
	end

	frb_serial u_serial (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.info          (info_s3),
		.codes         (codes),
		.tx_id         (tx_id_q),
		.hop_code      (hop_code_q),
		.out_stall     (out_stall),
		.ready         (ser_ready),
		.out_valid     (out_valid),
		.frame_byte    (frame_byte),
		.byte_position (byte_position),
		.final_byte    (final_byte),
		.synth_channel (synth_channel)
	);

endmodule

// ===== rtl/frb_sched.sv =====
// packet scheduler: slot bit, failsafe counter and hop channel state
// builds the four-bit command and lane modes per item; uses frb_pkg
module frb_sched (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  logic [frb_pkg::HOP_W-1:0]            hop_code,
	input  logic [frb_pkg::CHANNELS-1:0]         fs_mask,
	input  logic [4:0]                           active,
	output frb_pkg::pkt_info_t                   info,
	output frb_pkg::mode_vec_t                   modes
);

	logic                          slot_q;
	logic [frb_pkg::CNT_W-1:0]     fcnt_q;
	logic [frb_pkg::HOP_W-1:0]     hop_q;
	logic [frb_pkg::CNT_W-1:0]     fcnt_next;
	logic [frb_pkg::CMD_W-1:0]     cmd;
	logic [6:0]                    step;
	logic [6:0]                    hop_sum;
	logic [frb_pkg::HOP_W-1:0]     hop_next;

	always_comb begin
		fcnt_next = fcnt_q + frb_pkg::CNT_W'(slot_q);
		cmd = '0;
		cmd[frb_pkg::CMD_SLOT] = slot_q;
		if ((fcnt_next & frb_pkg::WRAP_MASK) == frb_pkg::WRAP_MASK) begin
			cmd[frb_pkg::CMD_FS] = (fcnt_next[0] == slot_q);
		end else begin
			cmd[frb_pkg::CMD_NORM] = 1'b1;
		end
		cmd[frb_pkg::CMD_UPPER] = fcnt_next[0];
	end

	always_comb begin
		for (int k = 0; k < frb_pkg::LANES; k++) begin
			logic [2:0] idx;
			idx = {cmd[frb_pkg::CMD_UPPER], 2'(k)};
			if (!cmd[frb_pkg::CMD_FS]) begin
				modes[k] = frb_pkg::MODE_STICK;
			end else if ((5'(idx) < active) && fs_mask[idx]) begin
				modes[k] = frb_pkg::MODE_FS;
			end else begin
				modes[k] = frb_pkg::MODE_HOLD;
			end
		end
	end

	always_comb begin
		step    = 7'(hop_code) + 7'd2;
		hop_sum = 7'(hop_q) + step;
		if (hop_sum > frb_pkg::HOP_LIMIT) begin
			if (hop_sum == frb_pkg::HOP_SKIP) begin
				hop_sum = hop_sum + step;
			end
			hop_sum = hop_sum - frb_pkg::HOP_MOD;
		end
		hop_next = hop_sum[frb_pkg::HOP_W-1:0];
	end

	assign info.cmd   = cmd;
	assign info.hop   = hop_q;
	assign info.synth = {1'b0, hop_q, 2'b00} + {2'b00, hop_q, 1'b0} + frb_pkg::SYNTH_BASE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= 1'b0;
			fcnt_q <= '0;
			hop_q  <= '0;
		end else if (accept) begin
			slot_q <= ~slot_q;
			fcnt_q <= fcnt_next;
			if (slot_q) begin
				hop_q <= hop_next;
			end
		end
	end

endmodule

// ===== rtl/frb_lane.sv =====
// one channel lane: stick scaling by reciprocal multiply with one correction,
// clamp and code selection over three registered stages; uses frb_pkg
module frb_lane #(
	parameter int FULL_SCALE = 10000
) (
	input  logic                               clk,
	input  frb_pkg::pipe_en_t                  pipe,
	input  logic signed [frb_pkg::STICK_W-1:0] stick,
	input  frb_pkg::lane_mode_t                mode,
	input  logic [7:0]                         fs_byte,
	output logic [frb_pkg::CODE_W-1:0]         code
);

	localparam int  FRAC   = 20;
	localparam int  Q_MAX  = frb_pkg::STICK_MAX * frb_pkg::STICK_GAIN / FULL_SCALE;
	localparam int  QW     = $clog2(Q_MAX + 1);
	localparam longint K   = (longint'(frb_pkg::STICK_GAIN) << FRAC) / FULL_SCALE;
	localparam int  KW     = $clog2(K + 1);
	localparam int  MW     = frb_pkg::STICK_W + KW;
	localparam int  PRODW  = (MW > FRAC + QW) ? MW : FRAC + QW;
	localparam int  PW     = frb_pkg::PROD_W;
	localparam logic [KW-1:0] K_C  = KW'(K);
	localparam logic [PW:0]   FS_C = (PW+1)'(FULL_SCALE);

	logic signed [frb_pkg::STICK_W-1:0] stick_s1;
	frb_pkg::lane_mode_t                mode_s1;
	logic [7:0]                         fsb_s1;

	logic [QW-1:0]                      q0_s2;
	logic [PW-1:0]                      p410_s2;
	logic                               neg_s2;
	frb_pkg::lane_mode_t                mode_s2;
	logic [frb_pkg::CODE_W-1:0]         fsc_s2;

	logic [QW-1:0]                      q_s3;
	logic                               neg_s3;
	frb_pkg::lane_mode_t                mode_s3;
	logic [frb_pkg::CODE_W-1:0]         fsc_s3;

	logic [frb_pkg::STICK_W-1:0]        mag;
	logic [PRODW-1:0]                   prod_k;
	logic [PW:0]                        qfs;
	logic [PW:0]                        rem;
	logic signed [15:0]                 v;

	always_comb begin
		mag    = stick_s1[frb_pkg::STICK_W-1] ? frb_pkg::STICK_W'(-stick_s1)
		                                      : frb_pkg::STICK_W'(stick_s1);
		prod_k = PRODW'(mag) * PRODW'(K_C);
	end

	always_comb begin
		qfs = (PW+1)'(q0_s2) * FS_C;
		rem = {1'b0, p410_s2} - qfs;
	end

	always_ff @(posedge clk) begin
		if (pipe.en1) begin
			stick_s1 <= stick;
			mode_s1  <= mode;
			fsb_s1   <= fs_byte;
		end
		if (pipe.en2) begin
			q0_s2   <= prod_k[FRAC +: QW];
			p410_s2 <= PW'(mag) * PW'(frb_pkg::STICK_GAIN);
			neg_s2  <= stick_s1[frb_pkg::STICK_W-1];
			mode_s2 <= mode_s1;
			fsc_s2  <= frb_pkg::fs_code(fsb_s1);
		end
		if (pipe.en3) begin
			q_s3    <= q0_s2 + QW'(rem >= FS_C);
			neg_s3  <= neg_s2;
			mode_s3 <= mode_s2;
			fsc_s3  <= fsc_s2;
		end
	end

	always_comb begin
		v = neg_s3 ? frb_pkg::CODE_MID + 16'(q_s3) : frb_pkg::CODE_MID - 16'(q_s3);
		if (v > frb_pkg::CODE_MAX) begin
			v = frb_pkg::CODE_MAX;
		end else if (v < frb_pkg::CODE_MIN) begin
			v = frb_pkg::CODE_MIN;
		end
		unique case (mode_s3)
			frb_pkg::MODE_STICK: code = v[frb_pkg::CODE_W-1:0];
			frb_pkg::MODE_FS:    code = fsc_s3;
			frb_pkg::MODE_HOLD:  code = frb_pkg::HOLD_CODE;
			default:             code = frb_pkg::HOLD_CODE;
		endcase
	end

endmodule

// ===== rtl/frb_serial.sv =====
// frame packer and byte serialiser: packs 13 bytes into a frame register
// and emits one byte per cycle while out_stall is low; uses frb_pkg
module frb_serial (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  frb_pkg::pkt_info_t          info,
	input  frb_pkg::code_vec_t          codes,
	input  logic [15:0]                 tx_id,
	input  logic [frb_pkg::HOP_W-1:0]   hop_code,
	input  logic                        out_stall,
	output logic                        ready,
	output logic                        out_valid,
	output logic [7:0]                  frame_byte,
	output logic [frb_pkg::POS_W-1:0]   byte_position,
	output logic                        final_byte,
	output logic [7:0]                  synth_channel
);

	logic [7:0]                 frame_q [frb_pkg::FRAME_LEN];
	logic [7:0]                 synth_q;
	logic [frb_pkg::POS_W-1:0]  pos_q;
	logic                       full_q;
	logic [7:0]                 pk [frb_pkg::FRAME_LEN];
	logic [frb_pkg::CODE_W-1:0] c0, c1, c2, c3;
	logic                       take;

	always_comb begin
		c0 = codes[0];
		c1 = codes[1];
		c2 = codes[2];
		c3 = codes[3];
		if (info.cmd[frb_pkg::CMD_FS] && !info.cmd[frb_pkg::CMD_UPPER]) begin
			c2 = c2 | frb_pkg::THROTTLE_FLAG;
		end
		pk[0]  = frb_pkg::FRAME_HEAD;
		pk[1]  = tx_id[15:8];
		pk[2]  = tx_id[7:0];
		pk[3]  = 8'h00;
		pk[4]  = 8'h00;
		pk[5]  = {info.hop, c0[11:9]};
		pk[6]  = c0[8:1];
		pk[7]  = {c0[0], c1[11:5]};
		pk[8]  = {c1[4:0], c2[11:9]};
		pk[9]  = c2[8:1];
		pk[10] = {c2[0], c3[11:5]};
		pk[11] = {c3[4:0], hop_code[4:2]};
		pk[12] = {hop_code[1:0], 2'b00, info.cmd};
	end

	assign take          = full_q && !out_stall;
	assign ready         = !full_q || (take && (pos_q == frb_pkg::POS_LAST));
	assign out_valid     = full_q;
	assign frame_byte    = frame_q[pos_q];
	assign byte_position = pos_q;
	assign final_byte    = (pos_q == frb_pkg::POS_LAST);
	assign synth_channel = synth_q;

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= pk;
			synth_q <= info.synth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
		end else if (load) begin
			pos_q  <= '0;
			full_q <= 1'b1;
		end else if (take) begin
			if (pos_q == frb_pkg::POS_LAST) begin
				pos_q  <= '0;
				full_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule
